// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion forms for the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante at one edge implies cons at the next edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// like ASSERT_NEXT but also checked while reset is asserted
`define ASSERT_NEXT_NORST(label, clk, ante, cons, msg) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/fct_pkg.sv =====
// ---------------------------------------------------------------------------
// fct_pkg
// Types and constants shared by the frustum cull test block.
// ---------------------------------------------------------------------------
`default_nettype none

package fct_pkg;

   localparam int PROD_W = 40;
   localparam int DIST_W = 48;

   typedef enum logic [2:0] {
      OP_LOAD   = 3'd0,
      OP_POINT  = 3'd1,
      OP_SPHERE = 3'd2,
      OP_CUBE   = 3'd3,
      OP_BOX    = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      SHAPE_POINT,
      SHAPE_SPHERE,
      SHAPE_BOX
   } shape_type;

   typedef struct packed {
      logic        is_load;
      logic [2:0]  idx;
      shape_type   shape;
      logic [15:0] a;
      logic [15:0] b;
      logic [15:0] c;
      logic [31:0] d;
      logic [23:0] cx;
      logic [23:0] cy;
      logic [23:0] cz;
      logic [22:0] hx;
      logic [22:0] hy;
      logic [22:0] hz;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_out_type;

endpackage

`default_nettype wire

// ===== rtl/core/fct_front.sv =====
// ---------------------------------------------------------------------------
// fct_front
// Accepts request beats, drops unused opcodes and out-of-range loads, and
// turns each beat into a queue item (cube folded into box).
// ---------------------------------------------------------------------------
`default_nettype none

module fct_front #(
   parameter int NUM_PLANES = 6
) (
   input  wire logic               req_valid,
   input  wire logic               req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [2:0]         req_plane_index,
   input  wire logic signed [15:0] req_plane_a,
   input  wire logic signed [15:0] req_plane_b,
   input  wire logic signed [15:0] req_plane_c,
   input  wire logic signed [31:0] req_plane_d,
   input  wire logic signed [23:0] req_center_x,
   input  wire logic signed [23:0] req_center_y,
   input  wire logic signed [23:0] req_center_z,
   input  wire logic [22:0]        req_half_x,
   input  wire logic [22:0]        req_half_y,
   input  wire logic [22:0]        req_half_z,
   output fct_pkg::item_type       push_item,
   output logic                    push
);

   logic keep;

   always_comb begin
      push_item.is_load = 1'b0;
      push_item.idx     = req_plane_index;
      push_item.shape   = fct_pkg::SHAPE_POINT;
      push_item.a       = req_plane_a;
      push_item.b       = req_plane_b;
      push_item.c       = req_plane_c;
      push_item.d       = req_plane_d;
      push_item.cx      = req_center_x;
      push_item.cy      = req_center_y;
      push_item.cz      = req_center_z;
      push_item.hx      = req_half_x;
      push_item.hy      = req_half_y;
      push_item.hz      = req_half_z;
      keep              = 1'b1;
      case (req_opcode)
         fct_pkg::OP_LOAD: begin
            push_item.is_load = 1'b1;
            keep = (32'(req_plane_index) < 32'(NUM_PLANES));
         end
         fct_pkg::OP_POINT:  push_item.shape = fct_pkg::SHAPE_POINT;
         fct_pkg::OP_SPHERE: push_item.shape = fct_pkg::SHAPE_SPHERE;
         fct_pkg::OP_CUBE: begin
            push_item.shape = fct_pkg::SHAPE_BOX;
            push_item.hy    = req_half_x;
            push_item.hz    = req_half_x;
         end
         fct_pkg::OP_BOX:    push_item.shape = fct_pkg::SHAPE_BOX;
         default:            keep = 1'b0;
      endcase
      push = req_valid && !req_stall && keep;
   end

endmodule

`default_nettype wire

// ===== rtl/core/fct_queue.sv =====
// ---------------------------------------------------------------------------
// fct_queue
// Two-entry queue between the front and back parts.
// ---------------------------------------------------------------------------
`default_nettype none

module fct_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire fct_pkg::item_type  push_item,
   input  wire logic               pop,
   output fct_pkg::q_out_type      head,
   output logic                    full
);

   fct_pkg::item_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      full       = (cnt_ff == 2'd2);
      head.valid = (cnt_ff != 2'd0);
      head.item  = mem_ff[rd_ptr_ff];
      wr_ptr_in  = wr_ptr_ff ^ push;
      rd_ptr_in  = rd_ptr_ff ^ pop;
      cnt_in     = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/fct_back.sv =====
// ---------------------------------------------------------------------------
// fct_back
// Plane store and test pipeline: products, distance and margin sums,
// per-plane cull compare, visible reduction into the response register.
// ---------------------------------------------------------------------------
`default_nettype none

module fct_back #(
   parameter int NUM_PLANES = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fct_pkg::q_out_type head,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_visible
);

   localparam int PW = fct_pkg::PROD_W;
   localparam int DW = fct_pkg::DIST_W;

   logic signed [15:0] a_ff [NUM_PLANES];
   logic signed [15:0] b_ff [NUM_PLANES];
   logic signed [15:0] c_ff [NUM_PLANES];
   logic signed [31:0] d_ff [NUM_PLANES];

   logic                s1_valid_ff;
   fct_pkg::shape_type  s1_shape_ff;
   logic [22:0]         s1_hx_ff;
   logic signed [PW-1:0] p0_ff [NUM_PLANES];
   logic signed [PW-1:0] p1_ff [NUM_PLANES];
   logic signed [PW-1:0] p2_ff [NUM_PLANES];
   logic [PW-1:0]        q0_ff [NUM_PLANES];
   logic [PW-1:0]        q1_ff [NUM_PLANES];
   logic [PW-1:0]        q2_ff [NUM_PLANES];
   logic signed [31:0]   s1_d_ff [NUM_PLANES];

   logic                 s2_valid_ff;
   logic signed [DW-1:0] dist_ff [NUM_PLANES];
   logic [DW-1:0]        ext_ff  [NUM_PLANES];

   logic                  s3_valid_ff;
   logic [NUM_PLANES-1:0] cull_ff;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_visible_ff;
   logic en;

   logic [16:0] abs_a [NUM_PLANES];
   logic [16:0] abs_b [NUM_PLANES];
   logic [16:0] abs_c [NUM_PLANES];

   function automatic logic [16:0] abs17(input logic [15:0] v);
      logic [16:0] e;
      e = {v[15], v};
      return v[15] ? (~e + 17'd1) : e;
   endfunction

   always_comb begin
      en  = !rsp_valid_ff || !rsp_stall;
      pop = head.valid && en;
      rsp_valid_in = en ? s3_valid_ff : rsp_valid_ff;
      for (int i = 0; i < NUM_PLANES; i++) begin
         abs_a[i] = abs17(a_ff[i]);
         abs_b[i] = abs17(b_ff[i]);
         abs_c[i] = abs17(c_ff[i]);
      end
   end

   // plane store, written when a load beat leaves the queue
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            a_ff[i] <= '0;
            b_ff[i] <= '0;
            c_ff[i] <= '0;
            d_ff[i] <= '0;
         end
      end else if (pop && head.item.is_load) begin
         for (int i = 0; i < NUM_PLANES; i++) begin
            if (head.item.idx == 3'(i)) begin
               a_ff[i] <= head.item.a;
               b_ff[i] <= head.item.b;
               c_ff[i] <= head.item.c;
               d_ff[i] <= head.item.d;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            s1_valid_ff <= pop && !head.item.is_load;
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_shape_ff <= head.item.shape;
         s1_hx_ff    <= head.item.hx;
         for (int i = 0; i < NUM_PLANES; i++) begin
            p0_ff[i]   <= a_ff[i] * $signed(head.item.cx);
            p1_ff[i]   <= b_ff[i] * $signed(head.item.cy);
            p2_ff[i]   <= c_ff[i] * $signed(head.item.cz);
            q0_ff[i]   <= abs_a[i] * head.item.hx;
            q1_ff[i]   <= abs_b[i] * head.item.hy;
            q2_ff[i]   <= abs_c[i] * head.item.hz;
            s1_d_ff[i] <= d_ff[i];
         end
         for (int i = 0; i < NUM_PLANES; i++) begin
            dist_ff[i] <= {{8{p0_ff[i][PW-1]}}, p0_ff[i]}
                        + {{8{p1_ff[i][PW-1]}}, p1_ff[i]}
                        + {{8{p2_ff[i][PW-1]}}, p2_ff[i]}
                        + {{2{s1_d_ff[i][31]}}, s1_d_ff[i], 14'b0};
            case (s1_shape_ff)
               fct_pkg::SHAPE_POINT:  ext_ff[i] <= '0;
               fct_pkg::SHAPE_SPHERE: ext_ff[i] <= {11'b0, s1_hx_ff, 14'b0};
               fct_pkg::SHAPE_BOX:
                  ext_ff[i] <= {8'b0, q0_ff[i]} + {8'b0, q1_ff[i]} + {8'b0, q2_ff[i]};
               default:               ext_ff[i] <= '0;
            endcase
         end
         // culled when the farthest point along the normal is still behind
         for (int i = 0; i < NUM_PLANES; i++) begin
            cull_ff[i] <= 1'(DW'(dist_ff[i] + $signed(ext_ff[i])) >> (DW - 1));
         end
         rsp_visible_ff <= ~|cull_ff;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_visible = rsp_visible_ff;

endmodule

`default_nettype wire

// ===== rtl/core/frustum_cull_test.sv =====
// ---------------------------------------------------------------------------
// frustum_cull_test
// Six-plane view frustum cull test with a plane store.
// ---------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): opcode 0 loads plane req_plane_index with
//   a, b, c, d; opcodes 1..4 test a point, sphere, cube or box against all
//   stored planes. Loads, out-of-range loads and opcodes 5..7 give no beat.
//   Response channel (rsp_*): one beat with rsp_visible per test, in order.
//   A beat is taken at a clock edge with valid high and stall low.
// Throughput: one request beat per cycle, sustained, while rsp_stall is low.
// Pipeline: a test passes the queue entry, then the multiply, sum, compare
//   and reduce stages, before it shows on rsp_*.
// A load takes effect for every test accepted after it.
// Reset: synchronous, active high; clears all planes (every shape visible)
//   and empties the pipeline.
// Stall: while rsp_valid and rsp_stall are both high the response register
//   holds and the whole test pipeline freezes behind it; the two-entry queue
//   then fills and req_stall rises.
// ---------------------------------------------------------------------------
`default_nettype none

module frustum_cull_test #(
   parameter int NUM_PLANES = 6
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [2:0]         req_opcode,
   input  wire logic [2:0]         req_plane_index,
   input  wire logic signed [15:0] req_plane_a,
   input  wire logic signed [15:0] req_plane_b,
   input  wire logic signed [15:0] req_plane_c,
   input  wire logic signed [31:0] req_plane_d,
   input  wire logic signed [23:0] req_center_x,
   input  wire logic signed [23:0] req_center_y,
   input  wire logic signed [23:0] req_center_z,
   input  wire logic [22:0]        req_half_x,
   input  wire logic [22:0]        req_half_y,
   input  wire logic [22:0]        req_half_z,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_visible
);

   fct_pkg::item_type  push_item;
   fct_pkg::q_out_type head;
   logic               push;
   logic               pop;

   fct_front #(.NUM_PLANES(NUM_PLANES)) u_front (
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_plane_index (req_plane_index),
      .req_plane_a     (req_plane_a),
      .req_plane_b     (req_plane_b),
      .req_plane_c     (req_plane_c),
      .req_plane_d     (req_plane_d),
      .req_center_x    (req_center_x),
      .req_center_y    (req_center_y),
      .req_center_z    (req_center_z),
      .req_half_x      (req_half_x),
      .req_half_y      (req_half_y),
      .req_half_z      (req_half_z),
      .push_item       (push_item),
      .push            (push)
   );

   fct_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .full      (req_stall)
   );

   fct_back #(.NUM_PLANES(NUM_PLANES)) u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_visible (rsp_visible)
   );

endmodule

`default_nettype wire

// ===== rtl/core/fct_checker.sv =====
// ---------------------------------------------------------------------------
// fct_checker
// Port-level checks on the frustum cull test block, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module fct_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_stall,
   input wire logic rsp_valid,
   input wire logic rsp_stall,
   input wire logic rsp_visible
);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp beat dropped")
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_visible), "rsp changed while stalled")
   `ASSERT_NEXT_NORST(a_rst_rsp, clock, reset, !rsp_valid, "rsp valid after reset")
   `ASSERT_NEXT_NORST(a_rst_req, clock, reset, !req_stall, "req stalled after reset")
   `ASSERT_ALWAYS(a_rsp_known, clock, reset, !rsp_valid || (rsp_visible == 1'b0) || (rsp_visible == 1'b1), "rsp unknown")

endmodule

bind frustum_cull_test fct_checker u_fct_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_visible (rsp_visible)
);

`default_nettype wire
